// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion helper macros
// concurrent checks clocked on a rising edge, off while reset is asserted
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/mrto_pkg.sv -----
// ---------------------------------------------------------------------------
// mrto_pkg
// shared types and constants of the relocation converter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrto_pkg;

	// relocation type codes
	localparam logic [7:0] T_WORD32 = 8'd2;
	localparam logic [7:0] T_JUMP26 = 8'd4;
	localparam logic [7:0] T_HI16   = 8'd5;
	localparam logic [7:0] T_LO16   = 8'd6;

	// configuration register indexes
	localparam logic REG_SECTION_INDEX = 1'b0;
	localparam logic REG_SECTION_BASE  = 1'b1;

	// overlay window, low bound inclusive, high bound exclusive
	localparam logic [31:0] WIN_LOW  = 32'h80d0_0000;
	localparam logic [31:0] WIN_HIGH = 32'h8100_0000;
	localparam logic [31:0] SEG_MASK = 32'hf000_0000;

	typedef struct packed {
		logic [15:0] half;
		logic        valid;
		logic [23:0] offset;
	} pend_state_t;

	typedef struct packed {
		logic [31:0] word;
		logic        has_word;
		logic        unknown_type;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]  section_index;
		logic [31:0] section_base;
	} cfg_t;

	typedef struct packed {
		result_t     res;
		logic        consume;
		pend_state_t nxt;
	} conv_out_t;

endpackage

// ----- rtl/mips_reloc_to_overlay_reloc_core.sv -----
// ---------------------------------------------------------------------------
// mips_reloc_to_overlay_reloc_core
// a taken request passes the input stage, then the result register
// throughput: one request per cycle unless stalled; a paired lo16 makes two results
// reset: arst_n clears the configuration, the pending hi16 state and both valids
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mips_reloc_to_overlay_reloc_core
	import mrto_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // reloc_type[7:0], reloc_address[39:8], data_word[71:40]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // reloc_word[31:0]
	output logic [1:0]  m_tuser,   // has_word[0], unknown_type[1]
	output logic        m_tlast
);

	cfg_t        cfg;
	pend_state_t pend_q;
	conv_out_t   conv;

	logic        valid_s1;
	logic [7:0]  type_s1;
	logic [31:0] addr_s1;
	logic [31:0] data_s1;

	logic        out_valid_q;
	result_t     out_q;

	logic        load_out;
	logic        advance;

	mrto_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mrto_conv u_conv (
		.cfg           (cfg),
		.pend          (pend_q),
		.reloc_type    (type_s1),
		.reloc_address (addr_s1),
		.data_word     (data_s1),
		.conv          (conv)
	);

	assign load_out = valid_s1 && (!out_valid_q || m_tready);
	assign advance  = load_out && conv.consume;
	assign s_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			type_s1 <= s_tdata[7:0];
			addr_s1 <= s_tdata[39:8];
			data_s1 <= s_tdata[71:40];
		end
	end

	// pending hi16 state moves with every result produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load_out) begin
			pend_q <= conv.nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= conv.res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.word;
	assign m_tuser  = {out_q.unknown_type, out_q.has_word};
	assign m_tlast  = out_q.last;

	`ASSERT_NEXT(a_hi16_sets_pending, clk, arst_n,
		advance && type_s1 == T_HI16, pend_q.valid)
	`ASSERT_NEXT(a_split_keeps_item, clk, arst_n,
		load_out && !conv.res.last, valid_s1 && !pend_q.valid)
	`ASSERT_IMPLIES(a_first_half_not_taken, clk, arst_n,
		load_out && !conv.res.last, !s_tready)
	`ASSERT_IMPLIES(a_no_word_is_zero, clk, arst_n,
		m_tvalid && !m_tuser[0], m_tdata == 32'h0)

endmodule

// ----- rtl/mrto_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// mrto_cfg_regs
// section index and section base registers behind the write port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrto_cfg_regs
	import mrto_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SECTION_INDEX: cfg_q.section_index <= cfg_data[1:0];
				REG_SECTION_BASE:  cfg_q.section_base  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/mrto_conv.sv -----
// ---------------------------------------------------------------------------
// mrto_conv
// converts one relocation into one result and the next pending hi16 state
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrto_conv
	import mrto_pkg::*;
(
	input  cfg_t        cfg,
	input  pend_state_t pend,
	input  logic [7:0]  reloc_type,
	input  logic [31:0] reloc_address,
	input  logic [31:0] data_word,
	output conv_out_t   conv
);

	logic [31:0] off_full;
	logic [23:0] off;
	logic [31:0] hl_addr;
	logic [31:0] j_addr;

	function automatic result_t emit(input logic [1:0] sec, input logic [7:0] typ,
			input logic [31:0] addr, input logic [23:0] offs, input logic lst);
		result_t r;
		r = '0;
		r.last = lst;
		if (addr >= WIN_LOW && addr < WIN_HIGH) begin
			r.word = {2'(sec + 2'd1), typ[5:0], offs};
			r.has_word = 1'b1;
		end
		return r;
	endfunction

	assign off_full = reloc_address - cfg.section_base;
	assign off      = off_full[23:0];
	assign hl_addr  = {pend.half, 16'h0000} + {{16{data_word[15]}}, data_word[15:0]};
	assign j_addr   = {4'h0, data_word[25:0], 2'b00} | (cfg.section_base & SEG_MASK);

	always_comb begin
		conv          = '0;
		conv.res.last = 1'b1;
		conv.consume  = 1'b1;
		conv.nxt      = pend;
		case (reloc_type)
			T_HI16: begin
				conv.nxt.half   = data_word[15:0];
				conv.nxt.offset = off;
				conv.nxt.valid  = 1'b1;
			end
			T_LO16: begin
				// pending hi16 goes out first, the lo16 word follows as the next result
				if (pend.valid) begin
					conv.res       = emit(cfg.section_index, T_HI16, hl_addr,
						pend.offset, 1'b0);
					conv.consume   = 1'b0;
					conv.nxt.valid = 1'b0;
				end else begin
					conv.res = emit(cfg.section_index, T_LO16, hl_addr, off, 1'b1);
				end
			end
			T_JUMP26: conv.res = emit(cfg.section_index, T_JUMP26, j_addr, off, 1'b1);
			T_WORD32: conv.res = emit(cfg.section_index, T_WORD32, data_word, off, 1'b1);
			default:  conv.res.unknown_type = 1'b1;
		endcase
	end

endmodule

// ----- verif/mips_reloc_to_overlay_reloc_core_tb.sv -----
// ---------------------------------------------------------------------------
// mips_reloc_to_overlay_reloc_core_tb
// drives relocation requests into the converter and checks every result
// against a predictor kept in step with the section registers and the
// pending hi16 state; a directed pass covers the window edges, pairing and
// unknown types, then random phases run under changing idle and stall patterns
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_reloc_to_overlay_reloc_core_tb;
	import mrto_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 128;
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// last field in the lowest bits, as on s_tdata
	typedef struct packed {
		logic [31:0] data_word;
		logic [31:0] reloc_address;
		logic [7:0]  reloc_type;
	} reloc_req_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	reloc_req_t  request_queue[$];
	result_t     expected_words[$];

	int          send_idle_pct  = 0;
	int          ready_stall_pct = 0;
	int          error_count    = 0;
	int          requests_taken = 0;
	int          results_seen   = 0;
	int          quiet_cycles   = 0;

	// predictor copy of the registers and the pending hi16
	logic [1:0]  sec_index_q;
	logic [31:0] sec_base_q;
	logic [15:0] held_half;
	logic        hi_waiting;
	logic [23:0] hi_offset;

	mips_reloc_to_overlay_reloc_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t overlay_word(logic [7:0] kind, logic [31:0] addr,
			logic [23:0] off, logic is_last);
		result_t     r;
		logic [1:0]  sec_field;
		r         = '0;
		r.last    = is_last;
		sec_field = sec_index_q + 2'd1;
		if (addr >= WIN_LOW && addr < WIN_HIGH) begin
			r.has_word = 1'b1;
			r.word     = {sec_field, kind[5:0], off};
		end
		return r;
	endfunction

	task automatic predict_relocation(reloc_req_t req);
		logic [31:0] diff;
		logic [31:0] slo;
		logic [31:0] addr;
		logic [23:0] off;
		result_t     r;
		diff = req.reloc_address - sec_base_q;
		off  = diff[23:0];
		case (req.reloc_type)
			T_HI16: begin
				held_half  = req.data_word[15:0];
				hi_offset  = off;
				hi_waiting = 1'b1;
				r          = '0;
				r.last     = 1'b1;
				expected_words.push_back(r);
			end
			T_LO16: begin
				slo  = {{16{req.data_word[15]}}, req.data_word[15:0]};
				addr = {held_half, 16'h0000} + slo;
				if (hi_waiting) begin
					hi_waiting = 1'b0;
					expected_words.push_back(overlay_word(T_HI16, addr, hi_offset, 1'b0));
				end
				expected_words.push_back(overlay_word(T_LO16, addr, off, 1'b1));
			end
			T_JUMP26: begin
				addr = {4'h0, req.data_word[25:0], 2'b00} | (sec_base_q & SEG_MASK);
				expected_words.push_back(overlay_word(T_JUMP26, addr, off, 1'b1));
			end
			T_WORD32: begin
				expected_words.push_back(overlay_word(T_WORD32, req.data_word, off, 1'b1));
			end
			default: begin
				r              = '0;
				r.unknown_type = 1'b1;
				r.last         = 1'b1;
				expected_words.push_back(r);
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
		error_count++;
	endtask

	// driver: next request goes out once the previous one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= request_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// monitor: checks results, then predicts for the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			sec_index_q  = '0;
			sec_base_q   = '0;
			held_half    = '0;
			hi_waiting   = 1'b0;
			hi_offset    = '0;
			quiet_cycles = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SECTION_INDEX: sec_index_q = cfg_data[1:0];
					REG_SECTION_BASE:  sec_base_q  = cfg_data;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, '0);
				end else begin
					want = expected_words.pop_front();
					if (m_tdata !== want.word)
						report_mismatch("reloc_word", m_tdata, want.word);
					if (m_tuser[0] !== want.has_word)
						report_mismatch("has_word", 32'(m_tuser[0]), 32'(want.has_word));
					if (m_tuser[1] !== want.unknown_type)
						report_mismatch("unknown_type", 32'(m_tuser[1]),
							32'(want.unknown_type));
					if (m_tlast !== want.last)
						report_mismatch("last", 32'(m_tlast), 32'(want.last));
				end
				results_seen++;
			end
			if (s_tvalid && s_tready) begin
				predict_relocation(reloc_req_t'(s_tdata));
				requests_taken++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, expected_words.size());
		$display("TB_ERROR");
		$finish;
	end

	task automatic push_request(logic [7:0] kind, logic [31:0] addr, logic [31:0] data);
		reloc_req_t req;
		req.reloc_type    = kind;
		req.reloc_address = addr;
		req.data_word     = data;
		request_queue.push_back(req);
	endtask

	function automatic logic [31:0] pick_address(logic [31:0] base);
		if ($urandom_range(3) == 0)
			return $urandom;
		return base + $urandom_range(0, 32'h01ff_ffff);
	endfunction

	task automatic wait_until_idle();
		do @(negedge clk);
		while (request_queue.size() > 0 || s_tvalid || expected_words.size() > 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic index, logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic start_phase(idle_mode_t mode, logic [31:0] sec, logic [31:0] base);
		wait_until_idle();
		write_register(REG_SECTION_INDEX, sec);
		write_register(REG_SECTION_BASE, base);
		@(negedge clk);
		send_idle_pct   = (mode == IDLE_SENDER) ? 62 : (mode == IDLE_BOTH) ? 26 : 0;
		ready_stall_pct = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 26 : 0;
	endtask

	task automatic add_random_requests(int count, logic [31:0] base);
		int          n;
		int          pick;
		logic [15:0] hi;
		logic [31:0] data;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			data = $urandom;
			if (pick < 30) begin
				// hi16 aimed near the window, then its lo16, sometimes with an unknown type between
				hi = 16'h80d0 + 16'($urandom_range(0, 16'h30));
				push_request(T_HI16, pick_address(base), {data[31:16], hi});
				if ($urandom_range(9) == 0) begin
					push_request(8'($urandom_range(7, 255)), $urandom, $urandom);
					n++;
				end
				push_request(T_LO16, pick_address(base), $urandom);
				n += 2;
			end else if (pick < 40) begin
				push_request(T_LO16, pick_address(base), data);
				n++;
			end else if (pick < 55) begin
				if ($urandom_range(3) != 0)
					data[25:0] = 26'h034_0000 + 26'($urandom_range(0, 26'h0c_ffff));
				push_request(T_JUMP26, pick_address(base), data);
				n++;
			end else if (pick < 70) begin
				if ($urandom_range(3) != 0)
					data = 32'h80c0_0000 + $urandom_range(0, 32'h0050_0000);
				push_request(T_WORD32, pick_address(base), data);
				n++;
			end else if (pick < 85) begin
				push_request(T_HI16, pick_address(base), data);
				n++;
			end else begin
				push_request(8'($urandom_range(255)), $urandom, data);
				n++;
			end
		end
	endtask

	initial begin
		logic [31:0] rnd;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: lo16 on the reset half, pairing, window edges, offsets, unknowns
		start_phase(IDLE_NONE, 32'd0, 32'h8000_0000);
		push_request(T_LO16,   32'h8000_0004, 32'h0000_0000);
		push_request(T_HI16,   32'h8000_0000, 32'h0000_80d0);
		push_request(T_LO16,   32'h8000_0004, 32'h0000_0000);
		push_request(T_LO16,   32'h8000_0008, 32'h0000_ffff);
		push_request(T_HI16,   32'hffff_ffff, 32'hffff_80ff);
		push_request(T_HI16,   32'h7fff_ffff, 32'h0000_8100);
		push_request(8'hff,    32'h0000_0000, 32'hffff_ffff);
		push_request(T_LO16,   32'h0000_0000, 32'hffff_8000);
		push_request(T_HI16,   32'h8000_1000, 32'h0000_8100);
		push_request(T_LO16,   32'h8000_1004, 32'h0000_0000);
		push_request(T_WORD32, 32'h8000_0010, 32'h80d0_0000);
		push_request(T_WORD32, 32'h8000_0014, 32'h80ff_ffff);
		push_request(T_WORD32, 32'h8000_0018, 32'h8100_0000);
		push_request(T_WORD32, 32'h8000_001c, 32'h80cf_ffff);
		push_request(T_WORD32, 32'hffff_ffff, 32'hffff_ffff);
		push_request(T_WORD32, 32'h0000_0000, 32'h0000_0000);
		push_request(T_JUMP26, 32'h8000_0020, 32'h0034_0000);
		push_request(T_JUMP26, 32'h8000_0024, 32'h003f_ffff);
		push_request(T_JUMP26, 32'h8000_0028, 32'h0033_ffff);
		push_request(T_JUMP26, 32'h8000_002c, 32'hffff_ffff);
		push_request(8'h00,    32'h8000_0030, 32'h80d0_0000);
		push_request(8'h01,    32'h8000_0034, 32'h80d0_0000);
		push_request(8'h03,    32'h8000_0038, 32'h80d0_0000);
		push_request(8'h07,    32'h8000_003c, 32'h80d0_0000);

		start_phase(IDLE_SENDER, 32'd1, 32'h8000_0000);
		add_random_requests(PHASE_ITEMS, 32'h8000_0000);
		start_phase(IDLE_RECEIVER, 32'd2, 32'h80d0_0000);
		add_random_requests(PHASE_ITEMS, 32'h80d0_0000);
		start_phase(IDLE_BOTH, 32'd3, 32'hffff_ffff);
		add_random_requests(PHASE_ITEMS, 32'hffff_ffff);
		start_phase(IDLE_NONE, 32'd0, 32'h0000_0000);
		add_random_requests(PHASE_ITEMS, 32'h0000_0000);
		rnd = {4'h8, 28'($urandom)};
		start_phase(IDLE_SENDER, {30'($urandom), 2'd2}, rnd);
		add_random_requests(PHASE_ITEMS, rnd);
		rnd = $urandom;
		start_phase(IDLE_RECEIVER, 32'd1, rnd);
		add_random_requests(PHASE_ITEMS, rnd);
		start_phase(IDLE_BOTH, 32'd0, 32'h8fff_ffff);
		add_random_requests(PHASE_ITEMS, 32'h8fff_ffff);
		start_phase(IDLE_NONE, 32'hffff_fffe, 32'h8000_0000);
		add_random_requests(PHASE_ITEMS, 32'h8000_0000);

		wait_until_idle();
		$display("ran %0d relocation requests and checked %0d results over 9 register settings",
			requests_taken, results_seen);
		$display("idle patterns: none, sender gaps, receiver stalls, both; %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
